FILE: design/ps2kbc_pkg.sv
// Shared types, constants and the key ROM of the PS/2 keyboard controller.
package ps2kbc_pkg;

  localparam logic [15:0] DATA_PORT      = 16'h0060;
  localparam logic [15:0] STAT_PORT      = 16'h0064;
  localparam logic [7:0]  SHIFT_MAKE     = 8'h2A;
  localparam logic [7:0]  SHIFT_BREAK    = 8'hAA;
  localparam logic [7:0]  KB_ACK         = 8'hFA;
  localparam logic [7:0]  CMD_RESET      = 8'hFF;
  localparam logic [7:0]  CMD_LED        = 8'hED;
  localparam logic [15:0] HOST_KEY_VALUE = 16'h1C0D;

  typedef enum logic [1:0] {
    MODE_INJECT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_TAKE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH,
    ST_RDATA,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       hit;
    logic       shift;
    logic [6:0] sc;
  } key_rom_t;

  function automatic key_rom_t key_lookup(input logic [8:0] key);
    logic [7:0] code;
    logic       hit;
    key_rom_t   r;
    hit  = 1'b1;
    code = 8'h00;
    unique case (key)
      9'h031: code = 8'h02;
      9'h032: code = 8'h03;
      9'h033: code = 8'h04;
      9'h034: code = 8'h05;
      9'h035: code = 8'h06;
      9'h036: code = 8'h07;
      9'h037: code = 8'h08;
      9'h038: code = 8'h09;
      9'h039: code = 8'h0A;
      9'h030: code = 8'h0B;
      9'h021: code = 8'h82;
      9'h040: code = 8'h83;
      9'h023: code = 8'h84;
      9'h024: code = 8'h85;
      9'h025: code = 8'h86;
      9'h05E: code = 8'h87;
      9'h026: code = 8'h88;
      9'h02A: code = 8'h89;
      9'h028: code = 8'h8A;
      9'h029: code = 8'h8B;
      9'h02D: code = 8'h0C;
      9'h03D: code = 8'h0D;
      9'h071: code = 8'h10;
      9'h077: code = 8'h11;
      9'h065: code = 8'h12;
      9'h072: code = 8'h13;
      9'h074: code = 8'h14;
      9'h079: code = 8'h15;
      9'h075: code = 8'h16;
      9'h069: code = 8'h17;
      9'h06F: code = 8'h18;
      9'h070: code = 8'h19;
      9'h05B: code = 8'h1A;
      9'h05D: code = 8'h1B;
      9'h061: code = 8'h1E;
      9'h073: code = 8'h1F;
      9'h064: code = 8'h20;
      9'h066: code = 8'h21;
      9'h067: code = 8'h22;
      9'h068: code = 8'h23;
      9'h06A: code = 8'h24;
      9'h06B: code = 8'h25;
      9'h06C: code = 8'h26;
      9'h03B: code = 8'h27;
      9'h07A: code = 8'h2C;
      9'h078: code = 8'h2D;
      9'h063: code = 8'h2E;
      9'h076: code = 8'h2F;
      9'h062: code = 8'h30;
      9'h06E: code = 8'h31;
      9'h06D: code = 8'h32;
      9'h02F: code = 8'h35;
      9'h00A: code = 8'h1C;
      9'h107: code = 8'h0E;
      9'h020: code = 8'h39;
      9'h02E: code = 8'h34;
      9'h02C: code = 8'h33;
      9'h03E: code = 8'hB4;
      9'h03C: code = 8'hB3;
      9'h05C: code = 8'h2B;
      9'h07C: code = 8'hAB;
      default: hit = 1'b0;
    endcase
    r.hit   = hit;
    r.shift = code[7];
    r.sc    = code[6:0];
    return r;
  endfunction

endpackage

FILE: design/ps2kbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ps2kbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/ps2_keyboard_controller_top.sv
// Top level of the emulated PS/2 keyboard controller with scancode ring buffer.
//
//  channel   dir  signals                      content
//  s_axis    in   tvalid/tready/tdata/tuser    tuser: mode; tdata: key, port, write data
//  m_axis    out  tvalid/tready/tdata          read data, host key, irq, unhandled, has_key
//
// One item at a time. After accept the item is decoded in ST_EXEC, then ST_PUSH
// writes the buffer bytes one by one through the single RAM write port (two or four
// for a key, one for an ack), ST_RDATA takes a data-port RAM read, ST_FINISH loads the result.
// The next item is taken once the result has been taken. Reset clears indexes,
// flags and the per-entry valid bits; entries never written read as zero.
module ps2_keyboard_controller_top #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // key_code[8:0], port[24:9], write_data[32:25]
  input  logic [1:0]  s_axis_tuser_i,   // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // read_data[7:0], host_key[23:8], irq[24],
                                        // unhandled[25], has_key[26]
);
  import ps2kbc_pkg::*;

  localparam int IDX_W = $clog2(BUFFER_DEPTH);

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(BUFFER_DEPTH - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [8:0]         key_q, key_d;
  logic [15:0]        port_q, port_d;
  logic [7:0]         wdata_q, wdata_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   tail_q, tail_d;
  logic               led_q, led_d;
  logic [BUFFER_DEPTH-1:0] valid_q, valid_d;
  logic [1:0]         push_idx_q, push_idx_d;
  logic [1:0]         push_last_q, push_last_d;
  logic               push_ack_q, push_ack_d;
  logic               shift_q, shift_d;
  logic [6:0]         sc_q, sc_d;
  logic               rd_ok_q, rd_ok_d;
  logic [7:0]         res_rd_q, res_rd_d;
  logic               res_hk_q, res_hk_d;
  logic               res_irq_q, res_irq_d;
  logic               res_unh_q, res_unh_d;
  logic               res_has_q, res_has_d;
  logic               out_valid_q, out_valid_d;

  key_rom_t           rom;
  logic               nonempty;
  logic               full;
  logic               ram_we;
  logic [7:0]         push_byte;
  logic [7:0]         ram_rdata;
  logic               in_fire;

  assign rom      = key_lookup(key_q);
  assign nonempty = head_q != tail_q;
  assign full     = ring_next(tail_q) == head_q;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, res_has_q, res_unh_q, res_irq_q,
                            (res_hk_q ? HOST_KEY_VALUE : 16'h0000), res_rd_q};

  always_comb begin
    if (push_ack_q) begin
      push_byte = KB_ACK;
    end else if (shift_q) begin
      case (push_idx_q)
        2'd0:    push_byte = SHIFT_MAKE;
        2'd1:    push_byte = {1'b0, sc_q};
        2'd2:    push_byte = {1'b1, sc_q};
        default: push_byte = SHIFT_BREAK;
      endcase
    end else begin
      push_byte = {push_idx_q[0], sc_q};
    end
  end

  ps2kbc_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(push_byte),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    port_d      = port_q;
    wdata_d     = wdata_q;
    head_d      = head_q;
    tail_d      = tail_q;
    led_d       = led_q;
    valid_d     = valid_q;
    push_idx_d  = push_idx_q;
    push_last_d = push_last_q;
    push_ack_d  = push_ack_q;
    shift_d     = shift_q;
    sc_d        = sc_q;
    rd_ok_d     = rd_ok_q;
    res_rd_d    = res_rd_q;
    res_hk_d    = res_hk_q;
    res_irq_d   = res_irq_q;
    res_unh_d   = res_unh_q;
    res_has_d   = res_has_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mode_d    = mode_e'(s_axis_tuser_i);
          key_d     = s_axis_tdata_i[8:0];
          port_d    = s_axis_tdata_i[24:9];
          wdata_d   = s_axis_tdata_i[32:25];
          res_rd_d  = 8'h00;
          res_hk_d  = 1'b0;
          res_irq_d = 1'b0;
          res_unh_d = 1'b0;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d    = ST_FINISH;
        push_idx_d = 2'd0;
        unique case (mode_q)
          MODE_INJECT: begin
            if (rom.hit) begin
              res_irq_d   = 1'b1;
              push_ack_d  = 1'b0;
              shift_d     = rom.shift;
              sc_d        = rom.sc;
              push_last_d = rom.shift ? 2'd3 : 2'd1;
              state_d     = ST_PUSH;
            end
          end
          MODE_READ: begin
            if (port_q == DATA_PORT) begin
              rd_ok_d = valid_q[head_q];
              if (nonempty) begin
                head_d = ring_next(head_q);
              end
              state_d = ST_RDATA;
            end else if (port_q == STAT_PORT) begin
              res_rd_d = {7'b0, nonempty};
            end else begin
              res_unh_d = 1'b1;
            end
          end
          MODE_WRITE: begin
            if (port_q == DATA_PORT &&
                (led_q || wdata_q == CMD_RESET || wdata_q == CMD_LED)) begin
              led_d       = !led_q && (wdata_q == CMD_LED);
              res_irq_d   = 1'b1;
              push_ack_d  = 1'b1;
              push_last_d = 2'd0;
              state_d     = ST_PUSH;
            end else begin
              res_unh_d = 1'b1;
            end
          end
          MODE_TAKE: begin
            if (nonempty) begin
              head_d   = tail_q;
              res_hk_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_PUSH: begin
        if (!full) begin
          ram_we          = 1'b1;
          valid_d[tail_q] = 1'b1;
          tail_d          = ring_next(tail_q);
        end
        if (push_idx_q == push_last_q) begin
          state_d = ST_FINISH;
        end else begin
          push_idx_d = push_idx_q + 2'd1;
        end
      end
      ST_RDATA: begin
        res_rd_d = rd_ok_q ? ram_rdata : 8'h00;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        res_has_d   = nonempty;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      led_q       <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      led_q       <= led_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    key_q       <= key_d;
    port_q      <= port_d;
    wdata_q     <= wdata_d;
    push_idx_q  <= push_idx_d;
    push_last_q <= push_last_d;
    push_ack_q  <= push_ack_d;
    shift_q     <= shift_d;
    sc_q        <= sc_d;
    rd_ok_q     <= rd_ok_d;
    res_rd_q    <= res_rd_d;
    res_hk_q    <= res_hk_d;
    res_irq_q   <= res_irq_d;
    res_unh_q   <= res_unh_d;
    res_has_q   <= res_has_d;
  end

  a_has_key_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_has_q == (head_q != tail_q)))
    else $error("has_key disagrees with buffer indexes");

  a_irq_unh_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_irq_q && res_unh_q))
    else $error("irq and unhandled both set");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC) && !s_axis_tready_o)
    else $error("input taken while busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (tail_q != head_q))
    else $error("push filled last free slot");

endmodule
